FILE: hdl/one_shot_frame_timer_bank_assert.svh
// Assertion macros used by the back end of the frame timer bank.
// Depends on nothing; included by the back end, which checks its own logic.
`ifndef ONE_SHOT_FRAME_TIMER_BANK_ASSERT_SVH
`define ONE_SHOT_FRAME_TIMER_BANK_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define OSTB_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define OSTB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define OSTB_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define OSTB_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

FILE: hdl/ostb_pkg.sv
// Shared types, codes and constants of the one-shot frame timer bank.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package ostb_pkg;

   localparam int NUM_TIMERS_DEFAULT = 16;
   localparam int CMD_DEPTH_DEFAULT  = 2;
   localparam int RSP_DEPTH_DEFAULT  = 2;

   localparam int RATE_W  = 8;
   localparam int ID_W    = 4;
   localparam int DUR_W   = 23;
   localparam int RAW_W   = 24;
   localparam int FRAME_W = 64;
   localparam int PROD_W  = DUR_W + RATE_W;

   localparam logic [RATE_W-1:0] FRAME_RATE_RESET = 8'd60;

   typedef enum logic [1:0] {
      OP_TICK    = 2'd0,
      OP_CREATE  = 2'd1,
      OP_DESTROY = 2'd2,
      OP_SET     = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      KIND_CREATE    = 3'd0,
      KIND_DESTROY   = 3'd1,
      KIND_SET       = 3'd2,
      KIND_EXPIRED   = 3'd3,
      KIND_TICK_DONE = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_DRAIN
   } eng_state_type;

   typedef struct packed {
      op_type                  op;
      logic [ID_W-1:0]         timer_id;
      logic signed [RAW_W-1:0] duration;
   } req_item_type;

   typedef struct packed {
      kind_type        kind;
      logic [ID_W-1:0] timer_slot;
      logic            ok;
      logic            last;
   } rsp_item_type;

   // Item after classification by the front end.
   typedef struct packed {
      op_type           op;
      logic [ID_W-1:0]  timer_id;
      logic             id_in_range;
      logic             dur_neg;
      logic             dur_zero;
      logic [DUR_W-1:0] dur_mag;
   } cmd_type;

   function automatic int slot_width(input int n);
      return (n > 1) ? $clog2(n) : 1;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/one_shot_frame_timer_bank.sv
// Top level of the one-shot frame timer bank: front end, back end, result queue.
// Depends on ostb_pkg, ostb_fifo, ostb_front and ostb_back.
//
//   channel   ports                           accepted when
//   request   req_push, req_full, req_item    req_push && !req_full
//   result    rsp_pop, rsp_empty, rsp_item    rsp_pop && !rsp_empty
//   config    csr_we, csr_wdata               csr_we
//
// A create, destroy or set passes through the idle and execute states after it
// leaves the command queue; a tick runs a slot scan that reads one slot per cycle,
// while the result queue has room, from the duration and start memories.
// Synchronous active-high reset clears all timers and sets the frame rate to 60.
// A full result queue freezes all but the idle pop; the command queue still fills.
`default_nettype none

module one_shot_frame_timer_bank import ostb_pkg::*; #(
   parameter int NUM_TIMERS = NUM_TIMERS_DEFAULT,
   parameter int CMD_DEPTH  = CMD_DEPTH_DEFAULT,
   parameter int RSP_DEPTH  = RSP_DEPTH_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   input  wire req_item_type      req_item,
   output logic                   req_full,
   input  wire logic              rsp_pop,
   output rsp_item_type           rsp_item,
   output logic                   rsp_empty,
   input  wire logic              csr_we,
   input  wire logic [RATE_W-1:0] csr_wdata
);

   cmd_type      cmd;
   logic         cmd_empty, cmd_pop;
   logic         eng_push, eng_full;
   rsp_item_type eng_item;

   ostb_front #(
      .NUM_TIMERS (NUM_TIMERS),
      .DEPTH      (CMD_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_item  (req_item),
      .req_full  (req_full),
      .cmd_pop   (cmd_pop),
      .cmd       (cmd),
      .cmd_empty (cmd_empty)
   );

   ostb_back #(
      .NUM_TIMERS (NUM_TIMERS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd_empty (cmd_empty),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_full  (eng_full),
      .rsp_push  (eng_push),
      .rsp_item  (eng_item)
   );

   ostb_fifo #(
      .WIDTH ($bits(rsp_item_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (eng_push),
      .wdata (eng_item),
      .full  (eng_full),
      .pop   (rsp_pop),
      .rdata (rsp_item),
      .empty (rsp_empty)
   );

endmodule

`default_nettype wire

FILE: hdl/ostb_fifo.sv
// Small register queue used between the block's parts and at its output.
// Depends on ostb_pkg for default sizing.
`default_nettype none

module ostb_fifo import ostb_pkg::*; #(
   parameter int WIDTH = 1,
   parameter int DEPTH = CMD_DEPTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] rdata,
   output logic                  empty
);

   localparam int PTR_W = slot_width(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/ostb_front.sv
// Front end: accepts request items, classifies them and queues the commands.
// Depends on ostb_pkg and ostb_fifo.
`default_nettype none

module ostb_front import ostb_pkg::*; #(
   parameter int NUM_TIMERS = NUM_TIMERS_DEFAULT,
   parameter int DEPTH      = CMD_DEPTH_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_push,
   input  wire req_item_type req_item,
   output logic              req_full,
   input  wire logic         cmd_pop,
   output cmd_type           cmd,
   output logic              cmd_empty
);

   cmd_type cmd_in;

   always_comb begin
      cmd_in.op          = req_item.op;
      cmd_in.timer_id    = req_item.timer_id;
      cmd_in.id_in_range = (32'(req_item.timer_id) < 32'(NUM_TIMERS));
      cmd_in.dur_neg     = req_item.duration[RAW_W-1];
      cmd_in.dur_zero    = (req_item.duration == '0);
      cmd_in.dur_mag     = req_item.duration[DUR_W-1:0];
   end

   ostb_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (DEPTH)
   ) u_cmd_queue (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .wdata (cmd_in),
      .full  (req_full),
      .pop   (cmd_pop),
      .rdata (cmd),
      .empty (cmd_empty)
   );

endmodule

`default_nettype wire

FILE: hdl/ostb_back.sv
// Back end: timer state, slot memories, command execution and tick scan.
// Depends on ostb_pkg and the assertion macro header.
`default_nettype none
`include "one_shot_frame_timer_bank_assert.svh"

module ostb_back import ostb_pkg::*; #(
   parameter int NUM_TIMERS = NUM_TIMERS_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_we,
   input  wire logic [RATE_W-1:0] csr_wdata,
   input  wire logic              cmd_empty,
   input  wire cmd_type           cmd,
   output logic                   cmd_pop,
   input  wire logic              rsp_full,
   output logic                   rsp_push,
   output rsp_item_type           rsp_item
);

   localparam int SLOT_W = slot_width(NUM_TIMERS);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_TIMERS - 1);

   eng_state_type state_ff, state_in;
   cmd_type       cmd_ff;

   logic [RATE_W-1:0]     frame_rate_ff;
   logic [FRAME_W-1:0]    frame_count_ff;
   logic [NUM_TIMERS-1:0] live_ff;
   logic [NUM_TIMERS-1:0] expired_ff;

   logic [SLOT_W-1:0] alloc_idx_ff, alloc_idx_in;
   logic              alloc_any_ff, alloc_any_in;

   logic [DUR_W-1:0]   dur_mem   [NUM_TIMERS];
   logic [FRAME_W-1:0] start_mem [NUM_TIMERS];

   // Scan pipeline: address, memory read, multiply and subtract, compare.
   logic [SLOT_W-1:0]  scan_idx_ff;
   logic               v1_ff, arm1_ff;
   logic [SLOT_W-1:0]  slot1_ff;
   logic [DUR_W-1:0]   dur_rd_ff;
   logic [FRAME_W-1:0] start_rd_ff;
   logic               v2_ff, arm2_ff;
   logic [SLOT_W-1:0]  slot2_ff;
   logic [PROD_W-1:0]  prod2_ff;
   logic [FRAME_W-1:0] elapsed2_ff;

   logic              adv, exec_go, scan_go, done_go, fire, fire_go;
   logic [31:0]       need_sum;
   logic [SLOT_W-1:0] id_idx, wr_idx;
   logic              id_ok, create_ok, dur_we, start_we;
   logic [DUR_W-1:0]  dur_wdata;

   // The lowest free slot is registered; an idle cycle always separates
   // two executed commands, so it is current when a create runs.
   always_comb begin
      alloc_idx_in = '0;
      alloc_any_in = 1'b0;
      for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
         if (!live_ff[i]) begin
            alloc_idx_in = SLOT_W'(i);
            alloc_any_in = 1'b1;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               state_in = (cmd.op == OP_TICK) ? ST_SCAN : ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (adv) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (adv && (scan_idx_ff == LAST_SLOT)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (adv && !v1_ff && !v2_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      adv       = !rsp_full;
      cmd_pop   = (state_ff == ST_IDLE) && !cmd_empty;
      exec_go   = (state_ff == ST_EXEC) && adv;
      scan_go   = (state_ff == ST_SCAN) && adv;
      done_go   = (state_ff == ST_DRAIN) && adv && !v1_ff && !v2_ff;
      need_sum  = 32'(prod2_ff) + 32'd255;
      fire      = v2_ff && arm2_ff && (elapsed2_ff >= FRAME_W'(need_sum[31:8]));
      fire_go   = fire && adv;
      id_idx    = SLOT_W'(cmd_ff.timer_id);
      id_ok     = cmd_ff.id_in_range && live_ff[id_idx];
      create_ok = !cmd_ff.dur_neg && alloc_any_ff;
      wr_idx    = (cmd_ff.op == OP_CREATE) ? alloc_idx_ff : id_idx;
      dur_we    = exec_go && (((cmd_ff.op == OP_CREATE) && create_ok) ||
                              ((cmd_ff.op == OP_SET) && id_ok));
      start_we  = exec_go && (((cmd_ff.op == OP_CREATE) && create_ok) ||
                              ((cmd_ff.op == OP_SET) && id_ok &&
                               !cmd_ff.dur_neg && !cmd_ff.dur_zero));
      dur_wdata = ((cmd_ff.op == OP_SET) && (cmd_ff.dur_neg || cmd_ff.dur_zero)) ?
                  '0 : cmd_ff.dur_mag;

      rsp_push            = 1'b0;
      rsp_item.kind       = KIND_TICK_DONE;
      rsp_item.timer_slot = '0;
      rsp_item.ok         = 1'b1;
      rsp_item.last       = 1'b1;
      if (fire_go) begin
         rsp_push            = 1'b1;
         rsp_item.kind       = KIND_EXPIRED;
         rsp_item.timer_slot = ID_W'(slot2_ff);
         rsp_item.last       = 1'b0;
      end else if (done_go) begin
         rsp_push = 1'b1;
      end else if (exec_go) begin
         rsp_push = 1'b1;
         case (cmd_ff.op)
            OP_CREATE: begin
               rsp_item.kind       = KIND_CREATE;
               rsp_item.ok         = create_ok;
               rsp_item.timer_slot = create_ok ? ID_W'(alloc_idx_ff) : '0;
            end
            OP_DESTROY: begin
               rsp_item.kind       = KIND_DESTROY;
               rsp_item.ok         = id_ok;
               rsp_item.timer_slot = cmd_ff.timer_id;
            end
            OP_SET: begin
               rsp_item.kind       = KIND_SET;
               rsp_item.ok         = id_ok;
               rsp_item.timer_slot = cmd_ff.timer_id;
            end
            default: begin
               rsp_item.kind = KIND_TICK_DONE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         frame_rate_ff  <= FRAME_RATE_RESET;
         frame_count_ff <= '0;
         live_ff        <= '0;
         expired_ff     <= '1;
         scan_idx_ff    <= '0;
         v1_ff          <= 1'b0;
         v2_ff          <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            frame_rate_ff <= csr_wdata;
         end
         if (cmd_pop) begin
            scan_idx_ff <= '0;
            if (cmd.op == OP_TICK) begin
               frame_count_ff <= frame_count_ff + 1'b1;
            end
         end else if (scan_go) begin
            scan_idx_ff <= scan_idx_ff + 1'b1;
         end
         if (adv) begin
            v1_ff <= (state_ff == ST_SCAN);
            v2_ff <= v1_ff;
         end
         if (exec_go) begin
            case (cmd_ff.op)
               OP_CREATE: begin
                  if (create_ok) begin
                     live_ff[alloc_idx_ff]    <= 1'b1;
                     expired_ff[alloc_idx_ff] <= 1'b0;
                  end
               end
               OP_DESTROY: begin
                  if (id_ok) begin
                     live_ff[id_idx]    <= 1'b0;
                     expired_ff[id_idx] <= 1'b1;
                  end
               end
               OP_SET: begin
                  if (id_ok) begin
                     expired_ff[id_idx] <= cmd_ff.dur_neg || cmd_ff.dur_zero;
                  end
               end
               default: begin
               end
            endcase
         end
         if (fire_go) begin
            expired_ff[slot2_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      alloc_idx_ff <= alloc_idx_in;
      alloc_any_ff <= alloc_any_in;
      if (cmd_pop) begin
         cmd_ff <= cmd;
      end
      if (scan_go) begin
         slot1_ff <= scan_idx_ff;
         arm1_ff  <= live_ff[scan_idx_ff] && !expired_ff[scan_idx_ff];
      end
      if (adv) begin
         slot2_ff    <= slot1_ff;
         arm2_ff     <= arm1_ff;
         prod2_ff    <= PROD_W'(dur_rd_ff) * PROD_W'(frame_rate_ff);
         elapsed2_ff <= frame_count_ff - start_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (dur_we) begin
         dur_mem[wr_idx] <= dur_wdata;
      end
      if (start_we) begin
         start_mem[wr_idx] <= frame_count_ff;
      end
      if (scan_go) begin
         dur_rd_ff   <= dur_mem[scan_idx_ff];
         start_rd_ff <= start_mem[scan_idx_ff];
      end
   end

   `OSTB_ASSERT_IMPL(a_pop_in_idle, clock, reset, cmd_pop, state_ff == ST_IDLE, "command taken outside idle")
   `OSTB_ASSERT_IMPL(a_stage_in_scan, clock, reset, v1_ff, (state_ff == ST_SCAN) || (state_ff == ST_DRAIN), "scan stage busy outside a tick")
   `OSTB_ASSERT_IMPL(a_push_has_room, clock, reset, rsp_push, !rsp_full, "result pushed into a full queue")
   `OSTB_ASSERT_NEXT(a_tick_counts, clock, reset, cmd_pop && (cmd.op == OP_TICK), frame_count_ff == $past(frame_count_ff) + 64'd1, "frame count did not advance on a tick")

endmodule

`default_nettype wire

FILE: bench/tb_one_shot_frame_timer_bank.sv
// Self-checking bench for the one-shot frame timer bank: a directed command table, then
// random phases over several frame rates and handshake idling patterns.
// Depends on ostb_pkg and one_shot_frame_timer_bank; every result is checked in order.
module tb_one_shot_frame_timer_bank;
   timeunit 1ns;
   timeprecision 1ps;
   import ostb_pkg::*;

   localparam int SLOTS          = NUM_TIMERS_DEFAULT;
   localparam int ITEMS_PER_PASS = 40;
   localparam int NUM_PASSES     = 5;
   localparam int SETTLE_CYCLES  = 2 * (SLOTS + 4);
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int REPORT_LIMIT   = 10;
   localparam int SCRIPT_LEN     = 21;

   typedef struct packed {
      req_item_type cmd;
      logic         typed;
      rsp_item_type want;
   } script_row_type;

   // Rows with typed set carry the reply that follows directly from the command.
   localparam script_row_type SCRIPT [SCRIPT_LEN] = '{
      '{'{OP_TICK,    4'd0,  24'h000000}, 1'b1, '{KIND_TICK_DONE, 4'd0,  1'b1, 1'b1}},
      '{'{OP_DESTROY, 4'd0,  24'h000000}, 1'b1, '{KIND_DESTROY,   4'd0,  1'b0, 1'b1}},
      '{'{OP_SET,     4'd15, 24'h000100}, 1'b1, '{KIND_SET,       4'd15, 1'b0, 1'b1}},
      '{'{OP_CREATE,  4'd0,  24'hFFFFFF}, 1'b1, '{KIND_CREATE,    4'd0,  1'b0, 1'b1}},
      '{'{OP_CREATE,  4'd0,  24'h800000}, 1'b1, '{KIND_CREATE,    4'd0,  1'b0, 1'b1}},
      '{'{OP_CREATE,  4'd0,  24'h000000}, 1'b1, '{KIND_CREATE,    4'd0,  1'b1, 1'b1}},
      '{'{OP_CREATE,  4'd0,  24'h7FFFFF}, 1'b1, '{KIND_CREATE,    4'd1,  1'b1, 1'b1}},
      '{'{OP_TICK,    4'd0,  24'h000000}, 1'b0, '0},
      '{'{OP_TICK,    4'd0,  24'h000000}, 1'b1, '{KIND_TICK_DONE, 4'd0,  1'b1, 1'b1}},
      '{'{OP_SET,     4'd1,  24'h000000}, 1'b1, '{KIND_SET,       4'd1,  1'b1, 1'b1}},
      '{'{OP_SET,     4'd1,  24'h800000}, 1'b1, '{KIND_SET,       4'd1,  1'b1, 1'b1}},
      '{'{OP_SET,     4'd1,  24'h000100}, 1'b1, '{KIND_SET,       4'd1,  1'b1, 1'b1}},
      '{'{OP_CREATE,  4'd5,  24'h000001}, 1'b0, '0},
      '{'{OP_TICK,    4'd0,  24'h000000}, 1'b0, '0},
      '{'{OP_CREATE,  4'd0,  24'h0000FF}, 1'b0, '0},
      '{'{OP_DESTROY, 4'd0,  24'h000000}, 1'b1, '{KIND_DESTROY,   4'd0,  1'b1, 1'b1}},
      '{'{OP_DESTROY, 4'd0,  24'h000000}, 1'b1, '{KIND_DESTROY,   4'd0,  1'b0, 1'b1}},
      '{'{OP_SET,     4'd0,  24'h000100}, 1'b1, '{KIND_SET,       4'd0,  1'b0, 1'b1}},
      '{'{OP_CREATE,  4'd0,  24'h7FFFFF}, 1'b0, '0},
      '{'{OP_DESTROY, 4'd15, 24'h000000}, 1'b1, '{KIND_DESTROY,   4'd15, 1'b0, 1'b1}},
      '{'{OP_TICK,    4'd15, 24'hFFFFFF}, 1'b0, '0}
   };

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_push  = 1'b0;
   req_item_type      req_item  = '0;
   logic              req_full;
   logic              rsp_pop   = 1'b0;
   rsp_item_type      rsp_item;
   logic              rsp_empty;
   logic              csr_we    = 1'b0;
   logic [RATE_W-1:0] csr_wdata = '0;

   // Predicted state of the timer bank.
   logic [FRAME_W-1:0] cur_frame;
   logic               slot_in_use [SLOTS];
   logic               slot_fired  [SLOTS];
   logic [DUR_W-1:0]   slot_dur    [SLOTS];
   logic [FRAME_W-1:0] slot_start  [SLOTS];
   logic [RATE_W-1:0]  rate_setting;

   rsp_item_type fresh_rsp   [$];
   rsp_item_type pending_rsp [$];

   int mismatch_count = 0;
   int quiet_cycles   = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   one_shot_frame_timer_bank dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_item  (req_item),
      .req_full  (req_full),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item),
      .rsp_empty (rsp_empty),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic rsp_item_type reply(kind_type k, int slot, logic ok, logic last);
      rsp_item_type r;
      r.kind       = k;
      r.timer_slot = ID_W'(slot);
      r.ok         = ok;
      r.last       = last;
      return r;
   endfunction

   // Applies one command to the predicted state and appends its results to fresh_rsp.
   function automatic void predict_item(input req_item_type it);
      logic [31:0]        need;
      logic [FRAME_W-1:0] elapsed;
      logic               neg;
      logic               hit;
      int                 slot;
      int                 i;
      neg  = it.duration[RAW_W-1];
      hit  = slot_in_use[it.timer_id];
      slot = -1;
      case (it.op)
         OP_TICK: begin
            cur_frame = cur_frame + 1'b1;
            for (i = 0; i < SLOTS; i++) begin
               if (slot_in_use[i] && !slot_fired[i]) begin
                  // Frames needed are the ceiling of duration * rate / 256.
                  need    = (32'(slot_dur[i]) * 32'(rate_setting) + 32'd255) >> 8;
                  elapsed = cur_frame - slot_start[i];
                  if (elapsed >= FRAME_W'(need)) begin
                     slot_fired[i] = 1'b1;
                     fresh_rsp.push_back(reply(KIND_EXPIRED, i, 1'b1, 1'b0));
                  end
               end
            end
            fresh_rsp.push_back(reply(KIND_TICK_DONE, 0, 1'b1, 1'b1));
         end
         OP_CREATE: begin
            if (!neg) begin
               for (i = SLOTS - 1; i >= 0; i--) begin
                  if (!slot_in_use[i]) slot = i;
               end
            end
            if (slot < 0) begin
               fresh_rsp.push_back(reply(KIND_CREATE, 0, 1'b0, 1'b1));
            end else begin
               slot_in_use[slot] = 1'b1;
               slot_fired[slot]  = 1'b0;
               slot_dur[slot]    = it.duration[DUR_W-1:0];
               slot_start[slot]  = cur_frame;
               fresh_rsp.push_back(reply(KIND_CREATE, slot, 1'b1, 1'b1));
            end
         end
         OP_DESTROY: begin
            if (hit) begin
               slot_in_use[it.timer_id] = 1'b0;
               slot_fired[it.timer_id]  = 1'b1;
            end
            fresh_rsp.push_back(reply(KIND_DESTROY, it.timer_id, hit, 1'b1));
         end
         default: begin
            if (hit) begin
               if (neg || it.duration == '0) begin
                  // The start frame is kept; the timer simply stops.
                  slot_fired[it.timer_id] = 1'b1;
                  slot_dur[it.timer_id]   = '0;
               end else begin
                  slot_fired[it.timer_id] = 1'b0;
                  slot_dur[it.timer_id]   = it.duration[DUR_W-1:0];
                  slot_start[it.timer_id] = cur_frame;
               end
            end
            fresh_rsp.push_back(reply(KIND_SET, it.timer_id, hit, 1'b1));
         end
      endcase
   endfunction

   function automatic req_item_type random_item();
      req_item_type it;
      int           r;
      int           tries;
      r = $urandom_range(99);
      if (r < 35) it.op = OP_TICK;
      else if (r < 65) it.op = OP_CREATE;
      else if (r < 80) it.op = OP_DESTROY;
      else it.op = OP_SET;
      // Most destroys and sets go to a live slot so that they do real work.
      it.timer_id = ID_W'($urandom_range(SLOTS - 1));
      if ($urandom_range(3) != 0) begin
         for (tries = 0; tries < SLOTS && !slot_in_use[it.timer_id]; tries++)
            it.timer_id = ID_W'($urandom_range(SLOTS - 1));
      end
      r = $urandom_range(99);
      if (r < 60) it.duration = RAW_W'($urandom_range(48));
      else if (r < 70) it.duration = '0;
      else if (r < 85) it.duration = {1'b1, DUR_W'($urandom)};
      else it.duration = RAW_W'($urandom);
      return it;
   endfunction

   task automatic log_mismatch(input string what, input rsp_item_type want);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("%0t: %s: expected kind %0d slot %0d ok %0d last %0d, got kind %0d slot %0d ok %0d last %0d",
                  $time, what, want.kind, want.timer_slot, want.ok, want.last,
                  rsp_item.kind, rsp_item.timer_slot, rsp_item.ok, rsp_item.last);
   endtask

   task automatic send_item(input req_item_type it, input logic typed,
                            input rsp_item_type want);
      req_item <= it;
      req_push <= 1'b1;
      do @(posedge clock); while (req_full !== 1'b0);
      fresh_rsp.delete();
      predict_item(it);
      if (typed) pending_rsp.push_back(want);
      else foreach (fresh_rsp[k]) pending_rsp.push_back(fresh_rsp[k]);
   endtask

   task automatic sender_gap();
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic drain_results(input int settle);
      req_push <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_rate(input logic [RATE_W-1:0] value);
      csr_wdata <= value;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we       <= 1'b0;
      rate_setting = value;
   endtask

   always @(posedge clock) begin
      rsp_pop <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            if (pending_rsp.size() == 0) begin
               log_mismatch("unexpected result", '0);
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_item.kind !== want.kind || rsp_item.timer_slot !== want.timer_slot ||
                   rsp_item.ok !== want.ok || rsp_item.last !== want.last)
                  log_mismatch("result mismatch", want);
            end
         end
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      req_item_type      it;
      logic [RATE_W-1:0] rate;
      int                pass;
      int                count;
      int                burst;
      int                r;
      cur_frame    = '0;
      rate_setting = FRAME_RATE_RESET;
      for (r = 0; r < SLOTS; r++) begin
         slot_in_use[r] = 1'b0;
         slot_fired[r]  = 1'b1;
         slot_dur[r]    = '0;
         slot_start[r]  = '0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (r = 0; r < SCRIPT_LEN; r++)
         send_item(SCRIPT[r].cmd, SCRIPT[r].typed, SCRIPT[r].want);

      for (pass = 0; pass < NUM_PASSES; pass++) begin
         drain_results(SETTLE_CYCLES);
         case (pass)
            0: rate = FRAME_RATE_RESET;
            1: rate = 8'd0;
            2: rate = 8'd255;
            3: rate = 8'd1;
            default: rate = RATE_W'($urandom_range(2, 254));
         endcase
         write_rate(rate);
         case (pass)
            1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
            3: begin send_idle_pct = 29; recv_stall_pct = 29; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
         endcase
         count = 0;
         while (count < ITEMS_PER_PASS) begin
            // In one pass the sender waits for all results if its count lands on half.
            if (pass == 3 && count == ITEMS_PER_PASS / 2) drain_results(0);
            // Runs of creates fill the bank so that later creates are refused.
            burst = ($urandom_range(9) == 0) ? $urandom_range(4, SLOTS + 1) : 1;
            repeat (burst) begin
               sender_gap();
               it = random_item();
               if (burst > 1) it.op = OP_CREATE;
               send_item(it, 1'b0, '0);
               count++;
            end
         end
      end

      drain_results(SETTLE_CYCLES);
      if (mismatch_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule
